>>> hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator package
// Field widths, request and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Widths of the item fields.
  localparam int unsigned ReqBytesW   = 16;
  localparam int unsigned OffsetW     = 17;
  localparam int unsigned FreeBytesW  = 18;
  localparam int unsigned BlockBytesW = 13;
  localparam int unsigned BlockCntW   = 6;
  localparam int unsigned ApbDataW    = 32;
  localparam int unsigned ApbAddrW    = 3;

  // Block size limits and reset values of the registers.
  localparam logic [BlockBytesW-1:0] BlockBytesMax   = 13'd4096;
  localparam logic [BlockBytesW-1:0] BlockBytesReset = 13'd64;
  localparam logic [BlockCntW-1:0]   BlockCntReset   = 6'd32;
  localparam logic [FreeBytesW-1:0]  FreeBytesMax    = 18'h3FFFF;

  // Request codes.
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  // Register indexes (bit 2 of the byte address).
  localparam logic RegBlockBytes = 1'b0;
  localparam logic RegBlocksUsed = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND,
    ST_FIT,
    ST_MARK,
    ST_FREE_SCAN,
    ST_WALK,
    ST_GOFF,
    ST_COUNT,
    ST_FBYTES,
    ST_DONE
  } state_e;

endpackage

>>> hw/rtl/bpa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator request channel
// Valid/ready channel carrying one allocate or free request per item.
// ----------------------------------------------------------------------------
interface bpa_req_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [bpa_pkg::ReqBytesW-1:0]   request_bytes;
  logic [bpa_pkg::OffsetW-1:0]     release_offset;

  modport source (output valid, req_type, request_bytes, release_offset, input ready);
  modport sink   (input valid, req_type, request_bytes, release_offset, output ready);
endinterface

>>> hw/rtl/bpa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator result channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface bpa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             granted;
  logic [bpa_pkg::OffsetW-1:0]      grant_offset;
  logic [bpa_pkg::FreeBytesW-1:0]   free_bytes;

  modport source (output valid, granted, grant_offset, free_bytes, input ready);
  modport sink   (input valid, granted, grant_offset, free_bytes, output ready);
endinterface

>>> hw/rtl/block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator
// First-fit allocator over a pool of equal blocks, with linked runs, driven
// by a small sequencer around one divider step and one shared multiplier.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake           | Payload
//  req_i    | in        | valid / ready       | req_type, request_bytes, release_offset
//  rsp_o    | out       | valid / ready       | granted, grant_offset, free_bytes
//  APB      | in        | psel/penable/pready | paddr, pwdata, prdata
//
//  Steps: an allocate of one block or more runs the divider, rounds up, scans
//  for a fit, marks each block of the run, forms the offset, counts the free
//  blocks, multiplies and hands off; a small allocate skips the divider and
//  marking, a free scans for the block at the release offset and walks one
//  linked block a cycle. Scans visit one block a cycle.
//  The request side is ready only while the sequencer is idle; a finished
//  result waits in the output register while the next item is accepted.
//  Reset clears all maps at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module block_pool_allocator #(
  parameter int unsigned NUM_BLOCKS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bpa_req_if.sink                        req_i,
  bpa_rsp_if.source                      rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpa_pkg::ApbAddrW-1:0]   paddr,
  input  logic [bpa_pkg::ApbDataW-1:0]   pwdata,
  output logic [bpa_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned IW = $clog2(NUM_BLOCKS);
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned BW = bpa_pkg::BlockBytesW;
  localparam int unsigned PW = CW + BW;

  // Configuration registers.
  logic [BW-1:0]                   cfg_bytes_q;
  logic [bpa_pkg::BlockCntW-1:0]   cfg_blocks_q;

  // Sequencer and working registers.
  bpa_pkg::state_e                 state_q, state_d;
  logic [CW-1:0]                   idx_q, idx_d;
  logic [CW-1:0]                   run_q, run_d;
  logic [CW-1:0]                   need_q, need_d;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic [CW-1:0]                   n_q, n_d;
  logic [IW-1:0]                   start_q, start_d;
  logic [BW-1:0]                   bs_q, bs_d;
  logic [bpa_pkg::ReqBytesW-1:0]   quo_q, quo_d;
  logic [BW-1:0]                   rem_q, rem_d;
  logic [3:0]                      step_q, step_d;
  logic                            small_q, small_d;
  logic                            req_type_q, req_type_d;
  logic [bpa_pkg::OffsetW-1:0]     rel_q, rel_d;
  logic                            grant_q, grant_d;
  logic [bpa_pkg::OffsetW-1:0]     goff_q, goff_d;
  logic [bpa_pkg::FreeBytesW-1:0]  fbytes_q, fbytes_d;

  // Block maps.
  logic [NUM_BLOCKS-1:0]           busy_q, busy_d;
  logic [NUM_BLOCKS-1:0]           head_q, head_d;
  logic [NUM_BLOCKS-1:0]           link_q, link_d;

  // Output register.
  logic                            out_valid_q, out_valid_d;
  logic                            out_granted_q, out_granted_d;
  logic [bpa_pkg::OffsetW-1:0]     out_goff_q, out_goff_d;
  logic [bpa_pkg::FreeBytesW-1:0]  out_fbytes_q, out_fbytes_d;

  // Helpers.
  logic [BW-1:0]                   bs_eff;
  logic [CW-1:0]                   n_eff;
  logic [CW-1:0]                   mul_a;
  logic [PW-1:0]                   mul_prod;
  logic [31:0]                     prod32;
  logic [IW-1:0]                   ix;
  logic [CW-1:0]                   idx_inc;
  logic [CW-1:0]                   run_inc;
  logic [CW-1:0]                   fit_start;
  logic [BW:0]                     div_shift;
  logic [BW:0]                     div_diff;
  logic [bpa_pkg::ReqBytesW:0]     need_full;
  logic                            cfg_wr;

  // APB register port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bytes_q  <= bpa_pkg::BlockBytesReset;
      cfg_blocks_q <= bpa_pkg::BlockCntReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bpa_pkg::RegBlockBytes: cfg_bytes_q  <= pwdata[BW-1:0];
        bpa_pkg::RegBlocksUsed: cfg_blocks_q <= pwdata[bpa_pkg::BlockCntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bpa_pkg::RegBlockBytes: prdata = bpa_pkg::ApbDataW'(cfg_bytes_q);
      bpa_pkg::RegBlocksUsed: prdata = bpa_pkg::ApbDataW'(cfg_blocks_q);
      default:                prdata = '0;
    endcase
  end

  // Effective block size and block count for the next item.
  always_comb begin
    if (cfg_bytes_q == '0) begin
      bs_eff = BW'(1);
    end else if (cfg_bytes_q > bpa_pkg::BlockBytesMax) begin
      bs_eff = bpa_pkg::BlockBytesMax;
    end else begin
      bs_eff = cfg_bytes_q;
    end
    if (32'(cfg_blocks_q) > NUM_BLOCKS) begin
      n_eff = CW'(NUM_BLOCKS);
    end else begin
      n_eff = CW'(cfg_blocks_q);
    end
  end

  // Shared multiplier: block index or free count times block size.
  always_comb begin
    unique case (state_q)
      bpa_pkg::ST_FREE_SCAN: mul_a = idx_q;
      bpa_pkg::ST_GOFF:      mul_a = CW'(start_q);
      bpa_pkg::ST_FBYTES:    mul_a = cnt_q;
      default:               mul_a = '0;
    endcase
  end

  assign mul_prod = PW'(mul_a) * PW'(bs_q);
  assign prod32   = 32'(mul_prod);

  // Divider step and scan helpers.
  assign ix        = idx_q[IW-1:0];
  assign idx_inc   = idx_q + CW'(1);
  assign run_inc   = run_q + CW'(1);
  assign fit_start = idx_inc - need_q;
  assign div_shift = {rem_q, quo_q[bpa_pkg::ReqBytesW-1]};
  assign div_diff  = div_shift - {1'b0, bs_q};
  assign need_full = {1'b0, quo_q} + (bpa_pkg::ReqBytesW+1)'(rem_q != '0);

  // Sequencer: next state, map updates and result.
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    run_d         = run_q;
    need_d        = need_q;
    cnt_d         = cnt_q;
    n_d           = n_q;
    start_d       = start_q;
    bs_d          = bs_q;
    quo_d         = quo_q;
    rem_d         = rem_q;
    step_d        = step_q;
    small_d       = small_q;
    req_type_d    = req_type_q;
    rel_d         = rel_q;
    grant_d       = grant_q;
    goff_d        = goff_q;
    fbytes_d      = fbytes_q;
    busy_d        = busy_q;
    head_d        = head_q;
    link_d        = link_q;
    out_valid_d   = out_valid_q & ~rsp_o.ready;
    out_granted_d = out_granted_q;
    out_goff_d    = out_goff_q;
    out_fbytes_d  = out_fbytes_q;
    req_i.ready   = (state_q == bpa_pkg::ST_IDLE);

    unique case (state_q)
      // Take a request and pick its path.
      bpa_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          req_type_d = req_i.req_type;
          rel_d      = req_i.release_offset;
          bs_d       = bs_eff;
          n_d        = n_eff;
          grant_d    = 1'b0;
          goff_d     = '0;
          idx_d      = '0;
          run_d      = '0;
          quo_d      = req_i.request_bytes;
          rem_d      = '0;
          step_d     = '0;
          small_d    = 1'b0;
          need_d     = CW'(1);
          if (req_i.req_type == bpa_pkg::ReqFree) begin
            state_d = bpa_pkg::ST_FREE_SCAN;
          end else if (req_i.request_bytes == '0) begin
            state_d = bpa_pkg::ST_COUNT;
          end else if (req_i.request_bytes < bpa_pkg::ReqBytesW'(bs_eff)) begin
            small_d = 1'b1;
            state_d = bpa_pkg::ST_FIT;
          end else begin
            state_d = bpa_pkg::ST_DIV;
          end
        end
      end

      // Restoring division, one quotient bit a cycle.
      bpa_pkg::ST_DIV: begin
        if (!div_diff[BW]) begin
          rem_d = div_diff[BW-1:0];
          quo_d = {quo_q[bpa_pkg::ReqBytesW-2:0], 1'b1};
        end else begin
          rem_d = div_shift[BW-1:0];
          quo_d = {quo_q[bpa_pkg::ReqBytesW-2:0], 1'b0};
        end
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          state_d = bpa_pkg::ST_ROUND;
        end
      end

      // Round the block count up and check it against the pool.
      bpa_pkg::ST_ROUND: begin
        if (need_full > (bpa_pkg::ReqBytesW+1)'(n_q)) begin
          state_d = bpa_pkg::ST_COUNT;
        end else begin
          need_d  = need_full[CW-1:0];
          state_d = bpa_pkg::ST_FIT;
        end
      end

      // First fit: track the length of the current free run.
      bpa_pkg::ST_FIT: begin
        if (idx_q == n_q) begin
          state_d = bpa_pkg::ST_COUNT;
        end else if (busy_q[ix]) begin
          run_d = '0;
          idx_d = idx_inc;
        end else if (run_inc == need_q) begin
          grant_d = 1'b1;
          if (small_q) begin
            busy_d[ix] = 1'b1;
            start_d    = ix;
            state_d    = bpa_pkg::ST_GOFF;
          end else begin
            start_d = fit_start[IW-1:0];
            idx_d   = fit_start;
            run_d   = need_q;
            state_d = bpa_pkg::ST_MARK;
          end
        end else begin
          run_d = run_inc;
          idx_d = idx_inc;
        end
      end

      // Mark the run busy, set the head and link each block but the last to the next.
      bpa_pkg::ST_MARK: begin
        busy_d[ix] = 1'b1;
        link_d[ix] = (run_q != CW'(1));
        if (ix == start_q) begin
          head_d[ix] = 1'b1;
        end
        if (run_q == CW'(1)) begin
          state_d = bpa_pkg::ST_GOFF;
        end else begin
          run_d = run_q - CW'(1);
          idx_d = idx_inc;
        end
      end

      // Byte offset of the granted region.
      bpa_pkg::ST_GOFF: begin
        goff_d  = prod32[bpa_pkg::OffsetW-1:0];
        state_d = bpa_pkg::ST_COUNT;
      end

      // Find the block whose byte offset matches the release offset.
      bpa_pkg::ST_FREE_SCAN: begin
        if (idx_q == n_q) begin
          state_d = bpa_pkg::ST_COUNT;
        end else if (prod32 == 32'(rel_q)) begin
          busy_d[ix] = 1'b0;
          if (head_q[ix]) begin
            head_d[ix] = 1'b0;
            state_d    = bpa_pkg::ST_WALK;
          end else begin
            state_d = bpa_pkg::ST_COUNT;
          end
        end else begin
          idx_d = idx_inc;
        end
      end

      // Follow the links of a freed run, one block a cycle.
      bpa_pkg::ST_WALK: begin
        if (idx_inc < n_q && link_q[ix]) begin
          link_d[ix]                 = 1'b0;
          busy_d[idx_inc[IW-1:0]]    = 1'b0;
          idx_d                      = idx_inc;
        end else begin
          state_d = bpa_pkg::ST_COUNT;
        end
      end

      // Count the free managed blocks.
      bpa_pkg::ST_COUNT: begin
        if (idx_q == n_q) begin
          state_d = bpa_pkg::ST_FBYTES;
        end else begin
          if (!busy_q[ix]) begin
            cnt_d = cnt_q + CW'(1);
          end
          idx_d = idx_inc;
        end
      end

      // Free bytes, saturated to the field width.
      bpa_pkg::ST_FBYTES: begin
        if (prod32 > 32'(bpa_pkg::FreeBytesMax)) begin
          fbytes_d = bpa_pkg::FreeBytesMax;
        end else begin
          fbytes_d = prod32[bpa_pkg::FreeBytesW-1:0];
        end
        state_d = bpa_pkg::ST_DONE;
      end

      // Hand the result to the output register once it is free.
      bpa_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d   = 1'b1;
          out_granted_d = grant_q;
          out_goff_d    = goff_q;
          out_fbytes_d  = fbytes_q;
          state_d       = bpa_pkg::ST_IDLE;
        end
      end

      default: state_d = bpa_pkg::ST_IDLE;
    endcase

    // Every path into the count starts it from block zero.
    if (state_d == bpa_pkg::ST_COUNT && state_q != bpa_pkg::ST_COUNT) begin
      idx_d = '0;
      cnt_d = '0;
    end
  end

  // Control state and block maps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpa_pkg::ST_IDLE;
      busy_q      <= '0;
      head_q      <= '0;
      link_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      head_q      <= head_d;
      link_q      <= link_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    run_q         <= run_d;
    need_q        <= need_d;
    cnt_q         <= cnt_d;
    n_q           <= n_d;
    start_q       <= start_d;
    bs_q          <= bs_d;
    quo_q         <= quo_d;
    rem_q         <= rem_d;
    step_q        <= step_d;
    small_q       <= small_d;
    req_type_q    <= req_type_d;
    rel_q         <= rel_d;
    grant_q       <= grant_d;
    goff_q        <= goff_d;
    fbytes_q      <= fbytes_d;
    out_granted_q <= out_granted_d;
    out_goff_q    <= out_goff_d;
    out_fbytes_q  <= out_fbytes_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted      = out_granted_q;
  assign rsp_o.grant_offset = out_goff_q;
  assign rsp_o.free_bytes   = out_fbytes_q;

  // The request side is not ready in the cycle after an accepted item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request side ready straight after an accepted item");

  // A free never reports a grant.
  a_free_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpa_pkg::ST_DONE && req_type_q == bpa_pkg::ReqFree) |-> !grant_q)
    else $error("free request reports a grant");

  // Marking never runs with an empty remaining count.
  a_mark_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpa_pkg::ST_MARK) |-> (run_q != '0))
    else $error("run marking with zero blocks left");

  // A waiting result is not overwritten.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpa_pkg::ST_DONE && rsp_o.valid && !rsp_o.ready)
      |=> (state_q == bpa_pkg::ST_DONE))
    else $error("result handed over while the output register is full");

endmodule

>>> tb/tb_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator testbench
// Drives allocate and free requests through the request channel and checks
// every result item against a predictor of the pool. The predictor keeps its
// own copy of the busy, head and link maps and of both registers. Directed
// requests cover the special cases first. Random traffic under several block
// sizes and counts follows, including out-of-range register values. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_block_pool_allocator;
  import bpa_pkg::*;

  localparam int unsigned NumBlocks     = 32;
  localparam int unsigned MaxGap        = 18;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned TailCycles    = 200;
  localparam int unsigned WatchdogLimit = 3000;

  typedef struct packed {
    logic                  granted;
    logic [OffsetW-1:0]    grant_offset;
    logic [FreeBytesW-1:0] free_bytes;
  } pool_result_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  bpa_req_if req_bus ();
  bpa_rsp_if rsp_bus ();

  block_pool_allocator #(
    .NUM_BLOCKS(NumBlocks)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predicted pool state and register copies.
  bit [NumBlocks-1:0]   pool_busy;
  bit [NumBlocks-1:0]   pool_head;
  bit [NumBlocks-1:0]   pool_link;
  bit [BlockBytesW-1:0] cfg_block_bytes;
  bit [BlockCntW-1:0]   cfg_blocks_used;

  pool_result_t expected_results[$];
  int unsigned  fail_count;
  int unsigned  result_count;
  int unsigned  idle_cycles;
  bit           quiet_flow;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Block size as the pool uses it: zero counts as one, the top is 4096.
  function automatic int unsigned eff_block_bytes();
    int unsigned bs;
    bs = cfg_block_bytes;
    if (bs == 0) bs = 1;
    if (bs > BlockBytesMax) bs = BlockBytesMax;
    return bs;
  endfunction

  // Number of managed blocks, capped at the built depth.
  function automatic int unsigned eff_blocks_used();
    int unsigned n;
    n = cfg_blocks_used;
    if (n > NumBlocks) n = NumBlocks;
    return n;
  endfunction

  // Applies one request to the predicted pool and returns its result item.
  function automatic pool_result_t pool_predict(logic kind, logic [ReqBytesW-1:0] nbytes,
                                                logic [OffsetW-1:0] offs);
    int unsigned  bs;
    int unsigned  n;
    int unsigned  need;
    int unsigned  b;
    int unsigned  c;
    int unsigned  k;
    int unsigned  total;
    bit           fits;
    pool_result_t r;
    bs = eff_block_bytes();
    n  = eff_blocks_used();
    r  = '0;
    if (kind == ReqAlloc) begin
      if (nbytes != 0 && nbytes < bs) begin
        // Small request: lowest free block, head and link untouched.
        for (b = 0; b < n; b++) begin
          if (!pool_busy[b]) begin
            pool_busy[b]   = 1'b1;
            r.granted      = 1'b1;
            r.grant_offset = OffsetW'(b * bs);
            break;
          end
        end
      end else if (nbytes != 0) begin
        // Run of whole blocks, first fit inside the managed range.
        need = (nbytes + bs - 1) / bs;
        if (need <= n) begin
          for (b = 0; b + need <= n; b++) begin
            fits = 1'b1;
            for (c = 0; c < need; c++) begin
              if (pool_busy[b + c]) begin
                fits = 1'b0;
                break;
              end
            end
            if (fits) begin
              pool_head[b] = 1'b1;
              for (c = 0; c < need; c++) begin
                pool_busy[b + c] = 1'b1;
                pool_link[b + c] = (c + 1 < need);
              end
              r.granted      = 1'b1;
              r.grant_offset = OffsetW'(b * bs);
              break;
            end
          end
        end
      end
    end else begin
      // Free: a head walks its links, any other block frees only itself.
      for (b = 0; b < n; b++) begin
        if (b * bs == offs) begin
          if (!pool_head[b]) begin
            pool_busy[b] = 1'b0;
          end else begin
            k            = b;
            pool_head[b] = 1'b0;
            pool_busy[b] = 1'b0;
            while (k + 1 < n && pool_link[k]) begin
              pool_link[k] = 1'b0;
              k++;
              pool_busy[k] = 1'b0;
            end
          end
          break;
        end
      end
    end
    total = 0;
    for (b = 0; b < n; b++) begin
      if (!pool_busy[b]) total += bs;
    end
    if (total > FreeBytesMax) total = FreeBytesMax;
    r.free_bytes = FreeBytesW'(total);
    return r;
  endfunction

  // Idle cycles before an item on either side.
  function automatic int unsigned draw_gap();
    return quiet_flow ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // Offers one request and records its expected result once accepted.
  task automatic send_request(logic kind, logic [ReqBytesW-1:0] nbytes,
                              logic [OffsetW-1:0] offs);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid          <= 1'b1;
    req_bus.req_type       <= kind;
    req_bus.request_bytes  <= nbytes;
    req_bus.release_offset <= offs;
    do @(posedge clk); while (!req_bus.ready);
    expected_results.push_back(pool_predict(kind, nbytes, offs));
  endtask

  // Holds the request side until every expected result has arrived.
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_register(logic reg_idx, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == RegBlockBytes) cfg_block_bytes = value[BlockBytesW-1:0];
    else cfg_blocks_used = value[BlockCntW-1:0];
    @(posedge clk);
  endtask

  // Frees every busy managed block, lowest first.
  task automatic release_all();
    int unsigned b;
    for (b = 0; b < eff_blocks_used(); b++) begin
      if (pool_busy[b]) begin
        send_request(ReqFree, ReqBytesW'($urandom()), OffsetW'(b * eff_block_bytes()));
      end
    end
  endtask

  // One random request, mostly sizes and offsets that hit the live pool.
  task automatic send_random_request();
    int unsigned bs;
    int unsigned n;
    int unsigned sel;
    int unsigned k;
    int unsigned kmax;
    int unsigned sz;
    int unsigned busy_idx[$];
    int unsigned b;
    logic [OffsetW-1:0] offs;
    bs  = eff_block_bytes();
    n   = eff_blocks_used();
    sel = $urandom_range(0, 99);
    if (sel < 58) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        sz = 0;
      end else if (sel < 30) begin
        sz = (bs > 1) ? $urandom_range(1, bs - 1) : 1;
      end else if (sel < 88) begin
        kmax = (n < 6) ? n : 6;
        if (kmax == 0) kmax = 1;
        if ($urandom_range(0, 9) == 0) k = $urandom_range(1, n + 1);
        else k = $urandom_range(1, kmax);
        sz = k * bs - $urandom_range(0, bs - 1);
        if (sz > 65535) sz = 65535;
      end else begin
        sz = $urandom_range(0, 65535);
      end
      send_request(ReqAlloc, ReqBytesW'(sz), OffsetW'($urandom()));
    end else begin
      for (b = 0; b < n; b++) begin
        if (pool_busy[b]) busy_idx.push_back(b);
      end
      sel = $urandom_range(0, 99);
      if (sel < 75 && busy_idx.size() != 0) begin
        offs = OffsetW'(busy_idx[$urandom_range(0, busy_idx.size() - 1)] * bs);
      end else if (sel < 88) begin
        offs = OffsetW'($urandom_range(0, NumBlocks - 1) * bs);
      end else begin
        offs = OffsetW'($urandom());
      end
      send_request(ReqFree, ReqBytesW'($urandom()), offs);
    end
  endtask

  // Special cases under the reset configuration of 64 byte blocks, 32 blocks.
  task automatic test_directed_requests();
    send_request(ReqAlloc, 16'd0, 17'd0);        // zero bytes fails
    send_request(ReqAlloc, 16'd1, 17'h1FFFF);    // small grant, block 0
    send_request(ReqAlloc, 16'd64, 17'd0);       // exactly one block, run of one
    send_request(ReqAlloc, 16'd65, 17'd0);       // rounds up to two blocks
    send_request(ReqAlloc, 16'd192, 17'd0);      // three block run at block 4
    send_request(ReqFree, 16'hFFFF, 17'd320);    // middle of a run, keeps its link
    send_request(ReqAlloc, 16'd10, 17'd0);       // small grant takes that block back
    send_request(ReqFree, 16'd0, 17'd256);       // head walk frees the stale block too
    send_request(ReqFree, 16'd0, 17'd1);         // offset between blocks
    send_request(ReqFree, 16'd0, 17'h1FFFF);     // offset beyond the pool
    send_request(ReqAlloc, 16'hFFFF, 17'd0);     // run longer than the pool
    send_request(ReqFree, 16'd0, 17'd0);         // block without a head
    send_request(ReqAlloc, 16'd2048, 17'd0);     // whole pool, no fit
    send_request(ReqFree, 16'd0, 17'd64);
    send_request(ReqFree, 16'd0, 17'd128);
    send_request(ReqAlloc, 16'd2048, 17'd0);     // whole pool in one run
    send_request(ReqAlloc, 16'd1, 17'd0);        // pool full
    send_request(ReqAlloc, 16'd100, 17'd0);      // pool full, run request
    send_request(ReqFree, 16'd0, 17'd1984);      // last block alone
    send_request(ReqAlloc, 16'd63, 17'd0);       // largest small request
    send_request(ReqFree, 16'd0, 17'd0);         // head walk over the whole pool
  endtask

  // The link walk stops at the last managed block when the count shrinks.
  task automatic test_link_walk_bound();
    wait_drained();
    write_register(RegBlockBytes, 32'd64);
    write_register(RegBlocksUsed, 32'd32);
    release_all();
    send_request(ReqAlloc, 16'd1792, 17'd0);
    send_request(ReqAlloc, 16'd256, 17'd0);
    wait_drained();
    write_register(RegBlocksUsed, 32'd30);
    send_request(ReqFree, 16'd0, 17'd1792);
    wait_drained();
    write_register(RegBlocksUsed, 32'd32);
    send_request(ReqFree, 16'd0, 17'd1920);
    send_request(ReqFree, 16'd0, 17'd1984);
    release_all();
  endtask

  // Random traffic under one register setting, with a full drain halfway.
  task automatic test_random_traffic(int unsigned block_bytes, int unsigned used_blocks,
                                     int unsigned items);
    int unsigned i;
    wait_drained();
    write_register(RegBlockBytes, ($urandom() << BlockBytesW) | block_bytes);
    write_register(RegBlocksUsed, ($urandom() << BlockCntW) | used_blocks);
    for (i = 0; i < items; i++) begin
      if (i % 40 == 0) quiet_flow = ($urandom_range(0, 3) == 0);
      if (i == items / 2) wait_drained();
      send_random_request();
    end
    quiet_flow = 1'b0;
  endtask

  // Result side: random stalls, then check each accepted item.
  initial begin : result_checker
    int unsigned  stall;
    pool_result_t got;
    pool_result_t want;
    rsp_bus.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      got.granted      = rsp_bus.granted;
      got.grant_offset = rsp_bus.grant_offset;
      got.free_bytes   = rsp_bus.free_bytes;
      result_count++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d with nothing expected: granted=%0b offset=%0d free=%0d",
                   result_count, got.granted, got.grant_offset, got.free_bytes);
      end else begin
        want = expected_results.pop_front();
        if (got.granted !== want.granted || got.grant_offset !== want.grant_offset ||
            got.free_bytes !== want.free_bytes) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: expected g=%0b off=%0d free=%0d, got g=%0b off=%0d free=%0d",
                     result_count, want.granted, want.grant_offset, want.free_bytes,
                     got.granted, got.grant_offset, got.free_bytes);
        end
      end
    end
  end

  // Count cycles in which nothing moves on any port.
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: the run ends if the block stops making progress.
  initial begin : watchdog
    wait (idle_cycles >= WatchdogLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n                  <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    req_bus.valid          <= 1'b0;
    req_bus.req_type       <= ReqAlloc;
    req_bus.request_bytes  <= '0;
    req_bus.release_offset <= '0;
    pool_busy       = '0;
    pool_head       = '0;
    pool_link       = '0;
    cfg_block_bytes = BlockBytesReset;
    cfg_blocks_used = BlockCntReset;
    fail_count      = 0;
    result_count    = 0;
    idle_cycles     = 0;
    quiet_flow      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_requests();
    test_link_walk_bound();
    test_random_traffic(64, 32, 300);
    test_random_traffic(4096, 32, 200);
    test_random_traffic(1, 1, 60);
    test_random_traffic(0, 5, 80);
    test_random_traffic(8191, 63, 200);
    test_random_traffic(5000, 33, 100);
    test_random_traffic(0, 0, 60);
    test_random_traffic(7, 17, 200);
    test_random_traffic(13, 32, 250);
    test_random_traffic(4096, 1, 60);
    test_random_traffic(100, 2, 100);

    // Let the last results drain, then allow for any stray item.
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_req_if.sv
hw/rtl/bpa_rsp_if.sv
hw/rtl/block_pool_allocator.sv
tb/tb_block_pool_allocator.sv
